[rtl/price_level_order_book_defines.svh]
// ----------------------------------------------------------------------------
// Price level order book: assertion macros
// Shared assertion forms for the order book modules.
// ----------------------------------------------------------------------------
`ifndef PRICE_LEVEL_ORDER_BOOK_DEFINES_SVH
`define PRICE_LEVEL_ORDER_BOOK_DEFINES_SVH

// Same-cycle implication, sampled on the block clock outside reset.
`define PRB_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the block clock outside reset.
`define PRB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/prb_pkg.sv]
// ----------------------------------------------------------------------------
// Price level order book package
// Field widths, action codes and the command passed from front to back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prb_pkg;

   localparam int ID_W    = 12;
   localparam int TICK_W  = 11;
   localparam int QTY_W   = 24;
   localparam int COUNT_W = 13;

   // Action codes on the request channel.
   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_MODIFY = 2'd1;
   localparam logic [1:0] ACT_CANCEL = 2'd2;

   // Occupancy bitmap leaf word.
   localparam int LEAF_W  = 32;
   localparam int LEAF_SH = 5;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_MODIFY,
      OP_CANCEL,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [ID_W-1:0]     order_id;
      logic [TICK_W-1:0]   price_tick;
      logic                is_buy;
      logic                id_ok;
      logic                price_ok;
   } cmd_type;

endpackage

[rtl/prb_front.sv]
// ----------------------------------------------------------------------------
// Order book front end
// Accepts request transactions, range-checks and classifies them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prb_front #(
   parameter int ORDER_SLOTS  = 4096,
   parameter int PRICE_LEVELS = 2048
) (
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [47:0]       req_tdata,
   input  logic [2:0]        req_tuser,
   input  logic              queue_full,
   output logic              push,
   output prb_pkg::cmd_type  cmd
);

   logic [1:0]  action;
   logic [31:0] id_ext;
   logic [31:0] price_ext;

   // The queue takes a transaction whenever it has room.
   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   assign action    = req_tuser[1:0];
   assign id_ext    = 32'(req_tdata[11:0]);
   assign price_ext = 32'(req_tdata[22:12]);

   // Decode the action and flag out-of-range ids and prices.
   always_comb begin
      cmd.order_id   = req_tdata[11:0];
      cmd.price_tick = req_tdata[22:12];
      cmd.is_buy     = req_tuser[2];
      cmd.id_ok      = id_ext < 32'(ORDER_SLOTS);
      cmd.price_ok   = price_ext < 32'(PRICE_LEVELS);
      unique case (action)
         prb_pkg::ACT_ADD:    cmd.op = prb_pkg::OP_ADD;
         prb_pkg::ACT_MODIFY: cmd.op = prb_pkg::OP_MODIFY;
         prb_pkg::ACT_CANCEL: cmd.op = prb_pkg::OP_CANCEL;
         default:             cmd.op = prb_pkg::OP_NONE;
      endcase
   end

endmodule

[rtl/prb_queue.sv]
// ----------------------------------------------------------------------------
// Order book command queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  prb_pkg::cmd_type  din,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output prb_pkg::cmd_type  dout
);

   prb_pkg::cmd_type entry_ff [2];
   logic             wptr_ff, wptr_in;
   logic             rptr_ff, rptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = count_ff == 2'd2;
   assign valid   = count_ff != 2'd0;
   assign dout    = entry_ff[rptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   // Pointer and fill count updates.
   always_comb begin
      wptr_in  = do_push ? !wptr_ff : wptr_ff;
      rptr_in  = do_pop ? !rptr_ff : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= din;
      end
   end

endmodule

[rtl/prb_engine.sv]
// ----------------------------------------------------------------------------
// Order book back end
// Applies commands to the slot and level memories, finds best levels and
// drives the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "price_level_order_book_defines.svh"

module prb_engine #(
   parameter int ORDER_SLOTS  = 4096,
   parameter int PRICE_LEVELS = 2048
) (
   input  logic              clock,
   input  logic              reset,
   input  prb_pkg::cmd_type  cmd,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,
   output logic [0:0]        rsp_tuser
);

   localparam int LEAF_W = prb_pkg::LEAF_W;
   localparam int LEAF_SH = prb_pkg::LEAF_SH;
   localparam int SLOT_W = $clog2(ORDER_SLOTS);
   localparam int LVL_W  = $clog2(PRICE_LEVELS);
   localparam int NW     = (PRICE_LEVELS + LEAF_W - 1) / LEAF_W;
   localparam int WIW    = (NW > 1) ? $clog2(NW) : 1;
   localparam int CNT_W  = $clog2(ORDER_SLOTS + 1);
   localparam int CLR_N  = (ORDER_SLOTS > PRICE_LEVELS) ? ORDER_SLOTS : PRICE_LEVELS;
   localparam int CLR_W  = $clog2(CLR_N);
   localparam int SW     = LVL_W + 2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SLOT,
      ST_LEVEL,
      ST_FIND,
      ST_ENC
   } state_type;

   // Memories: slot word is {used, side, level}.
   logic [SW-1:0]     slot_mem    [ORDER_SLOTS];
   logic [CNT_W-1:0]  bid_cnt_mem [PRICE_LEVELS];
   logic [CNT_W-1:0]  ask_cnt_mem [PRICE_LEVELS];
   logic [LEAF_W-1:0] bid_map_mem [NW];
   logic [LEAF_W-1:0] ask_map_mem [NW];

   logic [SW-1:0]     slot_q;
   logic [CNT_W-1:0]  bid_cnt_q, ask_cnt_q;
   logic [LEAF_W-1:0] bid_map_q, ask_map_q;

   state_type         state_ff, state_in;
   logic [CLR_W-1:0]  clr_ff, clr_in;
   prb_pkg::cmd_type  cmd_ff, cmd_in;
   logic              upd_ff, upd_in;
   logic              inc_ff, inc_in;
   logic              side_ff, side_in;
   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   logic              ok_ff, ok_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [NW-1:0]     bid_sum_ff, bid_sum_in;
   logic [NW-1:0]     ask_sum_ff, ask_sum_in;
   logic              bid_any_ff, bid_any_in;
   logic              ask_any_ff, ask_any_in;
   logic [WIW-1:0]    bid_widx_ff, bid_widx_in;
   logic [WIW-1:0]    ask_widx_ff, ask_widx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [39:0]       rsp_data_ff, rsp_data_in;
   logic              rsp_ok_ff, rsp_ok_in;

   // Memory port controls.
   logic              slot_re, slot_we;
   logic [SLOT_W-1:0] slot_ra, slot_wa;
   logic [SW-1:0]     slot_wd;
   logic              cnt_re, bid_cnt_we, ask_cnt_we;
   logic [LVL_W-1:0]  cnt_ra, cnt_wa;
   logic [CNT_W-1:0]  cnt_wd;
   logic              map_re, bid_map_we, ask_map_we;
   logic [WIW-1:0]    bid_map_ra, ask_map_ra, map_wa;
   logic [LEAF_W-1:0] map_wd;

   // Working values.
   logic [31:0]       clr_ext, id_head_ext, id_ff_ext, price_ext, nlvl_ext, lvl_ext;
   logic              s_used, s_side;
   logic [LVL_W-1:0]  s_lvl;
   logic [CNT_W-1:0]  old_cnt, new_cnt;
   logic [LEAF_W-1:0] old_map, new_map;
   logic [WIW-1:0]    bid_hi, ask_lo;
   logic [LEAF_SH-1:0] bid_leaf, ask_leaf;
   logic [31:0]       bid_top_lvl, ask_low_lvl;
   logic              rsp_free;

   assign clr_ext     = 32'(clr_ff);
   assign id_head_ext = 32'(cmd.order_id);
   assign id_ff_ext   = 32'(cmd_ff.order_id);
   assign price_ext   = 32'(cmd_ff.price_tick);
   assign lvl_ext     = 32'(lvl_ff);
   assign s_used      = slot_q[SW-1];
   assign s_side      = slot_q[SW-2];
   assign s_lvl       = slot_q[LVL_W-1:0];
   assign rsp_free    = !rsp_valid_ff || rsp_tready;

   // Highest occupied bitmap word on the bid side, lowest on the ask side.
   always_comb begin
      bid_hi = '0;
      for (int i = 0; i < NW; i++) begin
         if (bid_sum_ff[i]) begin
            bid_hi = WIW'(i);
         end
      end
      ask_lo = '0;
      for (int i = NW - 1; i >= 0; i--) begin
         if (ask_sum_ff[i]) begin
            ask_lo = WIW'(i);
         end
      end
   end

   // Bit position of the best level within the fetched leaf words.
   always_comb begin
      bid_leaf = '0;
      for (int i = 0; i < LEAF_W; i++) begin
         if (bid_map_q[i]) begin
            bid_leaf = LEAF_SH'(i);
         end
      end
      ask_leaf = '0;
      for (int i = LEAF_W - 1; i >= 0; i--) begin
         if (ask_map_q[i]) begin
            ask_leaf = LEAF_SH'(i);
         end
      end
   end

   assign bid_top_lvl = bid_any_ff ? ((32'(bid_widx_ff) << LEAF_SH) | 32'(bid_leaf)) : 32'd0;
   assign ask_low_lvl = ask_any_ff ? ((32'(ask_widx_ff) << LEAF_SH) | 32'(ask_leaf)) : 32'd0;

   // Level count and bitmap update for the level being touched.
   always_comb begin
      old_cnt = side_ff ? bid_cnt_q : ask_cnt_q;
      if (inc_ff) begin
         new_cnt = old_cnt + CNT_W'(1);
      end else if (old_cnt != '0) begin
         new_cnt = old_cnt - CNT_W'(1);
      end else begin
         new_cnt = old_cnt;
      end
      old_map = side_ff ? bid_map_q : ask_map_q;
      new_map = old_map;
      new_map[lvl_ext[LEAF_SH-1:0]] = new_cnt != '0;
   end

   // Sequencer: next state, command decision and memory port controls.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      upd_in       = upd_ff;
      inc_in       = inc_ff;
      side_in      = side_ff;
      lvl_in       = lvl_ff;
      ok_in        = ok_ff;
      total_in     = total_ff;
      bid_sum_in   = bid_sum_ff;
      ask_sum_in   = ask_sum_ff;
      bid_any_in   = bid_any_ff;
      ask_any_in   = ask_any_ff;
      bid_widx_in  = bid_widx_ff;
      ask_widx_in  = ask_widx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_ok_in    = rsp_ok_ff;
      cmd_pop      = 1'b0;
      slot_re      = 1'b0;
      slot_ra      = id_head_ext[SLOT_W-1:0];
      slot_we      = 1'b0;
      slot_wa      = id_ff_ext[SLOT_W-1:0];
      slot_wd      = '0;
      cnt_re       = 1'b0;
      cnt_ra       = '0;
      bid_cnt_we   = 1'b0;
      ask_cnt_we   = 1'b0;
      cnt_wa       = lvl_ff;
      cnt_wd       = new_cnt;
      map_re       = 1'b0;
      bid_map_ra   = '0;
      ask_map_ra   = '0;
      bid_map_we   = 1'b0;
      ask_map_we   = 1'b0;
      map_wa       = lvl_ext[LEAF_SH+WIW-1:LEAF_SH];
      map_wd       = new_map;
      nlvl_ext     = 32'd0;
      unique case (state_ff)
         ST_CLEAR: begin
            slot_we    = clr_ext < 32'(ORDER_SLOTS);
            slot_wa    = clr_ext[SLOT_W-1:0];
            bid_cnt_we = clr_ext < 32'(PRICE_LEVELS);
            ask_cnt_we = clr_ext < 32'(PRICE_LEVELS);
            cnt_wa     = clr_ext[LVL_W-1:0];
            cnt_wd     = '0;
            bid_map_we = clr_ext < 32'(NW);
            ask_map_we = clr_ext < 32'(NW);
            map_wa     = clr_ext[WIW-1:0];
            map_wd     = '0;
            clr_in     = clr_ff + CLR_W'(1);
            if (clr_ff == CLR_W'(CLR_N - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               slot_re  = 1'b1;
               cmd_in   = cmd;
               state_in = ST_SLOT;
            end
         end
         ST_SLOT: begin
            upd_in  = 1'b0;
            inc_in  = 1'b0;
            ok_in   = 1'b0;
            side_in = s_side;
            lvl_in  = s_lvl;
            case (cmd_ff.op)
               prb_pkg::OP_ADD: begin
                  if (cmd_ff.id_ok && !s_used && cmd_ff.price_ok) begin
                     ok_in   = 1'b1;
                     upd_in  = 1'b1;
                     inc_in  = 1'b1;
                     side_in = cmd_ff.is_buy;
                     lvl_in  = price_ext[LVL_W-1:0];
                     slot_we = 1'b1;
                     slot_wd = {1'b1, cmd_ff.is_buy, price_ext[LVL_W-1:0]};
                  end
               end
               prb_pkg::OP_MODIFY: begin
                  ok_in = cmd_ff.id_ok && s_used;
               end
               prb_pkg::OP_CANCEL: begin
                  if (cmd_ff.id_ok && s_used) begin
                     ok_in   = 1'b1;
                     upd_in  = 1'b1;
                     slot_we = 1'b1;
                     slot_wd = {1'b0, s_side, s_lvl};
                  end
               end
               default: begin
                  ok_in = 1'b0;
               end
            endcase
            nlvl_ext   = 32'(lvl_in);
            cnt_re     = 1'b1;
            cnt_ra     = lvl_in;
            map_re     = 1'b1;
            bid_map_ra = nlvl_ext[LEAF_SH+WIW-1:LEAF_SH];
            ask_map_ra = nlvl_ext[LEAF_SH+WIW-1:LEAF_SH];
            state_in   = ST_LEVEL;
         end
         ST_LEVEL: begin
            if (upd_ff) begin
               bid_cnt_we = side_ff;
               ask_cnt_we = !side_ff;
               bid_map_we = side_ff;
               ask_map_we = !side_ff;
               if (side_ff) begin
                  bid_sum_in[map_wa] = new_map != '0;
               end else begin
                  ask_sum_in[map_wa] = new_map != '0;
               end
               total_in = inc_ff ? total_ff + CNT_W'(1) :
                          (total_ff != '0) ? total_ff - CNT_W'(1) : total_ff;
            end
            state_in = ST_FIND;
         end
         ST_FIND: begin
            map_re      = 1'b1;
            bid_map_ra  = bid_hi;
            ask_map_ra  = ask_lo;
            bid_any_in  = bid_sum_ff != '0;
            ask_any_in  = ask_sum_ff != '0;
            bid_widx_in = bid_hi;
            ask_widx_in = ask_lo;
            state_in    = ST_ENC;
         end
         ST_ENC: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_data_in  = {3'd0, prb_pkg::COUNT_W'(total_ff),
                               ask_low_lvl[prb_pkg::TICK_W-1:0], ask_any_ff,
                               bid_top_lvl[prb_pkg::TICK_W-1:0], bid_any_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         total_ff     <= '0;
         bid_sum_ff   <= '0;
         ask_sum_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         total_ff     <= total_in;
         bid_sum_ff   <= bid_sum_in;
         ask_sum_ff   <= ask_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      upd_ff      <= upd_in;
      inc_ff      <= inc_in;
      side_ff     <= side_in;
      lvl_ff      <= lvl_in;
      ok_ff       <= ok_in;
      bid_any_ff  <= bid_any_in;
      ask_any_ff  <= ask_any_in;
      bid_widx_ff <= bid_widx_in;
      ask_widx_ff <= ask_widx_in;
      rsp_data_ff <= rsp_data_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

   // Slot memory.
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
      if (slot_re) begin
         slot_q <= slot_mem[slot_ra];
      end
   end

   // Per-level order counts.
   always_ff @(posedge clock) begin
      if (bid_cnt_we) begin
         bid_cnt_mem[cnt_wa] <= cnt_wd;
      end
      if (ask_cnt_we) begin
         ask_cnt_mem[cnt_wa] <= cnt_wd;
      end
      if (cnt_re) begin
         bid_cnt_q <= bid_cnt_mem[cnt_ra];
         ask_cnt_q <= ask_cnt_mem[cnt_ra];
      end
   end

   // Occupancy bitmap leaf words.
   always_ff @(posedge clock) begin
      if (bid_map_we) begin
         bid_map_mem[map_wa] <= map_wd;
      end
      if (ask_map_we) begin
         ask_map_mem[map_wa] <= map_wd;
      end
      if (map_re) begin
         bid_map_q <= bid_map_mem[bid_map_ra];
         ask_map_q <= ask_map_mem[ask_map_ra];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ok_ff;

   // Checks on the back end bookkeeping.
   `PRB_ASSERT_IMP(a_total_bound, 1'b1, total_ff <= CNT_W'(ORDER_SLOTS), "resting count overran the slots")
   `PRB_ASSERT_IMP(a_no_pop_clear, state_ff == ST_CLEAR, !cmd_pop, "command taken during clearing")
   `PRB_ASSERT_NEXT(a_bid_marked, state_ff == ST_LEVEL && upd_ff && inc_ff && side_ff, bid_sum_ff != '0, "bid add left bid summary empty")
   `PRB_ASSERT_NEXT(a_ask_marked, state_ff == ST_LEVEL && upd_ff && inc_ff && !side_ff, ask_sum_ff != '0, "ask add left ask summary empty")

endmodule

[rtl/price_level_order_book.sv]
// ----------------------------------------------------------------------------
// Price level order book
// Resting order book with per-level counts and best bid and ask reporting.
// ----------------------------------------------------------------------------
// After reset the back end clears its memories, sweeping max(ORDER_SLOTS,
// PRICE_LEVELS) addresses, and starts no command until that is done; the
// two-deep queue may take up to two request transactions meanwhile. Each
// request then goes through the back end in order: a slot memory read, a level
// count and bitmap read-modify-write, a summary search and a leaf word search
// for the best levels, and the response load, which waits while the response register holds an
// untaken response. Requests queue two deep ahead of the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module price_level_order_book #(
   parameter int ORDER_SLOTS  = 4096,
   parameter int PRICE_LEVELS = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // order_id[11:0], price_tick[22:12], quantity[46:23]
   input  logic [2:0]  req_tuser,   // action[1:0], is_buy[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // bid_present[0], best_bid_tick[11:1], ask_present[12],
                                    // best_ask_tick[23:13], resting_count[36:24]
   output logic [0:0]  rsp_tuser    // ok[0]
);

   prb_pkg::cmd_type front_cmd, head_cmd;
   logic             push, queue_full, head_valid, head_pop;

   // Front end: accept and classify.
   prb_front #(
      .ORDER_SLOTS  (ORDER_SLOTS),
      .PRICE_LEVELS (PRICE_LEVELS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (front_cmd)
   );

   // Command queue between the two halves.
   prb_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (front_cmd),
      .full  (queue_full),
      .pop   (head_pop),
      .valid (head_valid),
      .dout  (head_cmd)
   );

   // Back end: book update and best level search.
   prb_engine #(
      .ORDER_SLOTS  (ORDER_SLOTS),
      .PRICE_LEVELS (PRICE_LEVELS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd        (head_cmd),
      .cmd_valid  (head_valid),
      .cmd_pop    (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
